FILE: hdl/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types, constants and helpers for the HHMMSS line to seconds block.
// ----------------------------------------------------------------------------
`default_nettype none

package hms_pkg;

	// line framing bytes and digit bounds
	localparam logic [7:0] BYTE_LF    = 8'd10;
	localparam logic [7:0] BYTE_CR    = 8'd13;
	localparam logic [7:0] BYTE_NUL   = 8'd0;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	// line length limits
	localparam int          LINE_LEN  = 6;
	localparam logic [2:0]  LEN_OK    = 3'd6;
	localparam logic [2:0]  COUNT_MAX = 3'd7;

	// range limits and scale factors
	localparam logic [6:0]  HOURS_MAX      = 7'd23;
	localparam logic [6:0]  MINSEC_MAX     = 7'd59;
	localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN   = 17'd60;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_LEN   = 2'd1,
		ST_DIGIT = 2'd2,
		ST_VALUE = 2'd3
	} hms_status_t;

	typedef logic [3:0] hms_digit_t;

	// running state of the line being collected
	typedef struct packed {
		logic [2:0]                  count;
		logic                        ended_by_zero;
		logic                        nondigit_seen;
		hms_digit_t [LINE_LEN-1:0]   digits;
	} hms_line_t;

	// two decimal digits to a value 0..99
	function automatic logic [6:0] pair_value(input hms_digit_t hi, input hms_digit_t lo);
		pair_value = {3'b000, hi} * 7'd10 + {3'b000, lo};
	endfunction

endpackage

`default_nettype wire

FILE: hdl/hms_line_acc.sv
// ----------------------------------------------------------------------------
// hms_line_acc
// Collects the bytes of one line: length count, terminator and digit flags,
// and the digit values of the first six characters. Count and flags are cleared by every line end.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_line_acc
	import hms_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  byte_in,
	output hms_line_t        line
);

	hms_line_t line_q;
	hms_line_t line_nxt;
	logic      is_end;
	logic      is_digit;

	assign is_end   = (byte_in == BYTE_LF) || (byte_in == BYTE_CR);
	assign is_digit = (byte_in >= ASCII_ZERO) && (byte_in <= ASCII_NINE);

	// next line state for the byte in stage one
	always_comb begin
		line_nxt = line_q;
		if (is_end) begin
			line_nxt.count         = '0;
			line_nxt.ended_by_zero = 1'b0;
			line_nxt.nondigit_seen = 1'b0;
		end else if (!line_q.ended_by_zero) begin
			if (byte_in == BYTE_NUL) begin
				line_nxt.ended_by_zero = 1'b1;
			end else begin
				if (line_q.count < LEN_OK) begin
					if (is_digit) begin
						for (int i = 0; i < LINE_LEN; i++) begin
							if (line_q.count == 3'(i)) begin
								line_nxt.digits[i] = byte_in[3:0];
							end
						end
					end else begin
						line_nxt.nondigit_seen = 1'b1;
					end
				end
				if (line_q.count != COUNT_MAX) begin
					line_nxt.count = line_q.count + 3'd1;
				end
			end
		end
	end

	// line state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (take) begin
			line_q <= line_nxt;
		end
	end

	assign line = line_q;

endmodule

`default_nettype wire

FILE: hdl/hms_eval.sv
// ----------------------------------------------------------------------------
// hms_eval
// Checks a finished line in order (length, digits, range, nonzero) and
// forms the status and the total in seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_eval
	import hms_pkg::*;
(
	input  wire hms_line_t     line,
	output hms_status_t        status,
	output logic [16:0]        total_seconds
);

	logic [6:0]  hours;
	logic [6:0]  minutes;
	logic [6:0]  seconds;
	logic [16:0] sum;

	assign hours   = pair_value(line.digits[0], line.digits[1]);
	assign minutes = pair_value(line.digits[2], line.digits[3]);
	assign seconds = pair_value(line.digits[4], line.digits[5]);

	// constant-scaled sum, only meaningful once the range check passes
	assign sum = {10'd0, hours} * SECS_PER_HOUR + {10'd0, minutes} * SECS_PER_MIN
		+ {10'd0, seconds};

	// checks in priority order
	always_comb begin
		status        = ST_OK;
		total_seconds = '0;
		if (line.count != LEN_OK) begin
			status = ST_LEN;
		end else if (line.nondigit_seen) begin
			status = ST_DIGIT;
		end else if (hours > HOURS_MAX || minutes > MINSEC_MAX || seconds > MINSEC_MAX) begin
			status = ST_VALUE;
		end else if (sum == '0) begin
			status = ST_VALUE;
		end else begin
			total_seconds = sum;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/hhmmss_line_to_seconds.sv
// ----------------------------------------------------------------------------
// hhmmss_line_to_seconds
// Path: a line end byte is registered in stage one, and its result in the output register once that is free.
// Throughput: one byte per cycle; input stalls only while a result is held
// in stage one and the output register is full and stalled.
// Reset: arst_n clears the line state and both valid flags asynchronously.
// ----------------------------------------------------------------------------
`default_nettype none

module hhmmss_line_to_seconds
	import hms_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   rx_byte,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [1:0]        status,
	output logic [16:0]       total_seconds
);

	logic          rx_valid_s1;
	logic [7:0]    rx_byte_s1;
	logic          end_s1;
	logic          out_free;
	logic          advance;
	logic          in_take;
	hms_line_t     line;
	hms_status_t   eval_status;
	logic [16:0]   eval_total;
	logic          out_valid_q;
	hms_status_t   status_q;
	logic [16:0]   total_q;

	// stage one can move on unless it holds a line end facing a full and stalled output
	assign end_s1   = (rx_byte_s1 == BYTE_LF) || (rx_byte_s1 == BYTE_CR);
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = !end_s1 || out_free;
	assign in_stall = rx_valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (in_take) begin
			rx_valid_s1 <= 1'b1;
		end else if (advance) begin
			rx_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// running line state
	hms_line_acc u_line_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (rx_valid_s1 && advance),
		.byte_in (rx_byte_s1),
		.line    (line)
	);

	// line checks and seconds total
	hms_eval u_eval (
		.line          (line),
		.status        (eval_status),
		.total_seconds (eval_total)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rx_valid_s1 && end_s1 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid_s1 && end_s1 && out_free) begin
			status_q <= eval_status;
			total_q  <= eval_total;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign total_seconds = total_q;

	// a good result always carries a nonzero total
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_OK |-> total_q != '0)
		else $error("ok result with zero total");

	// an error result always carries a zero total
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> total_q == '0)
		else $error("error result with nonzero total");

	// a line end clears the line count
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid_s1 && end_s1 && out_free |=> line.count == '0)
		else $error("line state not cleared after line end");

	// input stalls only behind a held line end and a blocked output
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> rx_valid_s1 && end_s1 && out_valid_q)
		else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
